@@ src/lca_pkg.sv @@
// ---------------------------------------------------------------------------
// lca_pkg: shared types and constants for the lowest common ancestor walk
// Item formats, operation codes, controller states and the command and
// status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package lca_pkg;

    localparam int ID_W    = 10;
    localparam int ENTRY_W = ID_W + 1;   // has-parent flag over parent id

    // operation codes of the op field
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_EDGE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]      op;
        logic [ID_W-1:0] parent_node;
        logic [ID_W-1:0] child_node;
        logic [ID_W-1:0] node_a;
        logic [ID_W-1:0] node_b;
    } s_item_t;

    typedef struct packed {
        logic [ID_W-1:0] ancestor;
        logic            found;
        logic            walk_error;
    } m_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_LIFT_LOAD,
        ST_LIFT,
        ST_JOIN,
        ST_OUT
    } state_t;

    // per-lane commands
    typedef struct packed {
        logic load;
        logic walk;
        logic step;
    } lane_cmd_t;

    typedef struct packed {
        logic done;
        logic err;
    } lane_stat_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_start;
        logic clr_write;
        logic edge_write;
        logic query_load;
        logic walk;
        logic lift_load;
        logic lift_step;
        logic join_step;
        logic out_load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic walk_done;
        logic walk_fail;
        logic lift_done;
        logic meet;
    } dp_stat_t;

endpackage

@@ src/lowest_common_ancestor_walk.sv @@
// ---------------------------------------------------------------------------
// lowest_common_ancestor_walk: parent table with naive ancestor query
// Keeps a parent table for a forest of NODES nodes and answers lowest
// common ancestor queries by walking the table upward.
// ---------------------------------------------------------------------------
// After reset, and after every clear item, the block sweeps the parent
// table one entry per cycle and takes no item until the sweep is done.
// An edge item is written as it is taken and yields no result. A query walks
// node_a and node_b to their roots side by side, one table read per lane per
// cycle (each lane has its own copy of the table, written in step); a walk
// that runs into a loop ends with a walk error. If both walks reach the same
// root, the deeper node is then lifted by the depth difference, one step a
// cycle, and both nodes climb together until they meet; the result register
// is loaded last. A query holds the input until its result is loaded. One
// item is worked on at a time; a finished result sits in an output register,
// so the next item is taken while it waits.
// Node ids at or above NODES are roots; an edge for such a child is dropped.
// ---------------------------------------------------------------------------
module lowest_common_ancestor_walk
    import lca_pkg::*;
#(
    parameter int NODES = 1024
) (
    input  logic    aclk,
    input  logic    aresetn,
    // input items
    input  logic    s_valid,
    output logic    s_ready,
    input  s_item_t s_item,
    // result items, one per query
    output logic    m_valid,
    input  logic    m_ready,
    output m_item_t m_item
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: decodes the op, steps through walk, lift and join
    lca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_item.op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // tables, walk lanes and result register
    lca_datapath #(.NODES(NODES)) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_item  (s_item),
        .stat    (stat),
        .m_item  (m_item)
    );

endmodule

@@ src/lca_ram.sv @@
// ---------------------------------------------------------------------------
// lca_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module lca_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/lca_walker.sv @@
// ---------------------------------------------------------------------------
// lca_walker: one upward-walk lane
// Holds the current node and step count; the table read address is the
// next node, so the parent entry of the current node is ready every cycle.
// ---------------------------------------------------------------------------
module lca_walker
    import lca_pkg::*;
#(
    parameter int NODES = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lane_cmd_t                      cmd,
    input  logic [ID_W-1:0]                load_node,
    input  logic [ENTRY_W-1:0]             rd_data,
    output logic [$clog2(NODES)-1:0]       rd_addr,
    output logic [ID_W-1:0]                cur,
    output logic [$clog2(NODES+1)-1:0]     cnt,
    output lane_stat_t                     stat
);

    localparam int AW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    logic [ID_W-1:0] cur_reg, cur_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    lane_stat_t      stat_reg, stat_next;
    logic            in_range;
    logic            has_par;
    logic [ID_W-1:0] par;

    // ids past the table are roots
    assign in_range = 32'(cur_reg) < NODES;
    assign has_par  = in_range && rd_data[ENTRY_W-1];
    assign par      = rd_data[ID_W-1:0];

    always_comb begin
        cur_next  = cur_reg;
        cnt_next  = cnt_reg;
        stat_next = stat_reg;
        if (cmd.load) begin
            cur_next  = load_node;
            cnt_next  = '0;
            stat_next = '0;
        end else if (cmd.walk && !stat_reg.done) begin
            if (!has_par) begin
                stat_next.done = 1'b1;
            end else if (32'(cnt_reg) >= NODES) begin
                stat_next.done = 1'b1;
                stat_next.err  = 1'b1;
            end else begin
                cur_next = par;
                cnt_next = cnt_reg + CW'(1);
            end
        end else if (cmd.step) begin
            cur_next = has_par ? par : cur_reg;
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stat_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            stat_reg <= stat_next;
            cnt_reg  <= cnt_next;
        end
        cur_reg <= cur_next;
    end

    assign rd_addr = AW'(cur_next);
    assign cur     = cur_reg;
    assign cnt     = cnt_reg;
    assign stat    = stat_reg;

endmodule

@@ src/lca_datapath.sv @@
// ---------------------------------------------------------------------------
// lca_datapath: parent tables, two walk lanes and the result register
// Both tables take the same writes so each lane has its own read port.
// ---------------------------------------------------------------------------
module lca_datapath
    import lca_pkg::*;
#(
    parameter int NODES = 1024
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  dp_cmd_t  cmd,
    input  s_item_t  s_item,
    output dp_stat_t stat,
    output m_item_t  m_item
);

    localparam int AW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    logic [AW-1:0]      clr_reg;
    logic [ID_W-1:0]    node_a_reg, node_b_reg;
    logic [CW-1:0]      diff_reg;
    logic               lift_a_reg;
    m_item_t            m_item_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [AW-1:0]      rd_addr_a, rd_addr_b;
    logic [ENTRY_W-1:0] rd_data_a, rd_data_b;
    lane_cmd_t          lcmd_a, lcmd_b;
    logic [ID_W-1:0]    load_a, load_b;
    logic [ID_W-1:0]    cur_a, cur_b;
    logic [CW-1:0]      cnt_a, cnt_b;
    lane_stat_t         lst_a, lst_b;
    logic               a_deeper;
    logic               walk_error;
    logic               meet;

    // table writes: clearing pass or edge record
    assign wr_en   = cmd.clr_write
                     || (cmd.edge_write && (32'(s_item.child_node) < NODES));
    assign wr_addr = cmd.clr_write ? clr_reg : AW'(s_item.child_node);
    assign wr_data = cmd.clr_write ? '0 : {1'b1, s_item.parent_node};

    lca_ram #(.WIDTH(ENTRY_W), .DEPTH(NODES)) u_ram_a (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    lca_ram #(.WIDTH(ENTRY_W), .DEPTH(NODES)) u_ram_b (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    assign load_a = cmd.query_load ? s_item.node_a : node_a_reg;
    assign load_b = cmd.query_load ? s_item.node_b : node_b_reg;

    always_comb begin
        lcmd_a.load = cmd.query_load || cmd.lift_load;
        lcmd_a.walk = cmd.walk;
        lcmd_a.step = (cmd.lift_step && lift_a_reg) || cmd.join_step;
        lcmd_b.load = cmd.query_load || cmd.lift_load;
        lcmd_b.walk = cmd.walk;
        lcmd_b.step = (cmd.lift_step && !lift_a_reg) || cmd.join_step;
    end

    lca_walker #(.NODES(NODES)) u_lane_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (lcmd_a),
        .load_node (load_a),
        .rd_data   (rd_data_a),
        .rd_addr   (rd_addr_a),
        .cur       (cur_a),
        .cnt       (cnt_a),
        .stat      (lst_a)
    );

    lca_walker #(.NODES(NODES)) u_lane_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (lcmd_b),
        .load_node (load_b),
        .rd_data   (rd_data_b),
        .rd_addr   (rd_addr_b),
        .cur       (cur_b),
        .cnt       (cnt_b),
        .stat      (lst_b)
    );

    // after the depth walks the lanes sit on the roots and counts hold depths
    assign a_deeper   = cnt_a > cnt_b;
    assign walk_error = lst_a.err || lst_b.err;
    assign meet       = cur_a == cur_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_start) begin
            clr_reg <= '0;
        end else if (cmd.clr_write) begin
            clr_reg <= clr_reg + AW'(1);
        end

        if (cmd.query_load) begin
            node_a_reg <= s_item.node_a;
            node_b_reg <= s_item.node_b;
        end
        if (cmd.lift_load) begin
            lift_a_reg <= a_deeper;
            diff_reg   <= a_deeper ? cnt_a - cnt_b : cnt_b - cnt_a;
        end
        if (cmd.out_load) begin
            m_item_reg.walk_error <= walk_error;
            m_item_reg.found      <= !walk_error && meet;
            m_item_reg.ancestor   <= (!walk_error && meet) ? cur_a : '0;
        end
    end

    always_comb begin
        stat.clr_last  = clr_reg == AW'(NODES - 1);
        stat.walk_done = lst_a.done && lst_b.done;
        stat.walk_fail = walk_error || !meet;
        stat.lift_done = (lift_a_reg ? cnt_a : cnt_b) == diff_reg;
        stat.meet      = meet;
    end

    assign m_item = m_item_reg;

endmodule

@@ src/lca_ctrl.sv @@
// ---------------------------------------------------------------------------
// lca_ctrl: sequencer for clear, edge write and ancestor query
// Owns the input ready and the output valid.
// ---------------------------------------------------------------------------
module lca_ctrl
    import lca_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_op,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_op)
                        OP_CLEAR: begin
                            cmd.clr_start = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        OP_EDGE: begin
                            cmd.edge_write = 1'b1;
                        end
                        OP_QUERY: begin
                            cmd.query_load = 1'b1;
                            state_next     = ST_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (stat.walk_done) begin
                    state_next = stat.walk_fail ? ST_OUT : ST_LIFT_LOAD;
                end
            end
            ST_LIFT_LOAD: begin
                cmd.lift_load = 1'b1;
                state_next    = ST_LIFT;
            end
            ST_LIFT: begin
                if (stat.lift_done) begin
                    state_next = ST_JOIN;
                end else begin
                    cmd.lift_step = 1'b1;
                end
            end
            ST_JOIN: begin
                if (stat.meet) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.join_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for lowest_common_ancestor_walk
// Drives clear, edge, ancestor query and spare op items with random idling on both
// channels. A local copy of the parent table predicts every query result,
// and each result is checked field by field, oldest first.
// ---------------------------------------------------------------------------
module tb_top;
    import lca_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         NODES_TB  = 1024;
    localparam logic [1:0] OP_UNUSED = 2'd3;   // spare op code, block drops it
    localparam int         HOLD_CYC  = 400;    // long receiver hold-off

    typedef struct {
        s_item_t item;
        bit      wait_results;   // offer only once every result is back
    } stim_t;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    s_item_t s_item  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    m_item_t m_item;

    // stimulus and prediction state
    stim_t                stim_q[$];
    m_item_t              ancestor_q[$];        // predicted query results
    logic [ENTRY_W-1:0]   forest [NODES_TB];    // has-parent flag, parent id
    bit                   drain_next = 1'b0;
    bit                   hold_off   = 1'b0;

    // counters; those read by other processes change only by NBA
    int n_total    = 0;
    int n_accepted = 0;
    int n_queries  = 0;
    int n_results  = 0;
    int n_edges    = 0;
    int n_clears   = 0;
    int n_found    = 0;
    int n_loops    = 0;
    int n_bad      = 0;
    int n_unexp    = 0;

    // no idling on either side over one stretch of items
    wire steady = (n_accepted >= 110) && (n_accepted < 150);

    always #2 aclk = ~aclk;

    lowest_common_ancestor_walk #(
        .NODES(NODES_TB)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------

    function automatic logic [ID_W-1:0] parent_of(logic [ID_W-1:0] node);
        return forest[node][ID_W] ? forest[node][ID_W-1:0] : node;
    endfunction

    // Walk up to the root; 0 when the walk runs past NODES steps (a loop).
    function automatic bit climb_to_root(input logic [ID_W-1:0] start,
                                         output int depth,
                                         output logic [ID_W-1:0] root);
        logic [ID_W-1:0] cur;
        int              steps;
        cur   = start;
        steps = 0;
        while (forest[cur][ID_W]) begin
            if (steps >= NODES_TB)
                return 1'b0;
            cur   = forest[cur][ID_W-1:0];
            steps = steps + 1;
        end
        depth = steps;
        root  = cur;
        return 1'b1;
    endfunction

    // Update the table for one accepted item; a query queues its answer.
    // Returns 1 when the item was a query.
    function automatic bit apply_to_forest(s_item_t it);
        logic [ID_W-1:0] a, b, ra, rb;
        int              da, db;
        bit              ok_a, ok_b;
        m_item_t         res;
        case (it.op)
            OP_CLEAR: begin
                foreach (forest[i])
                    forest[i] = '0;
                return 1'b0;
            end
            OP_EDGE: begin
                // child ids all lie below NODES at this size
                forest[it.child_node] = {1'b1, it.parent_node};
                return 1'b0;
            end
            OP_QUERY: begin
                a    = it.node_a;
                b    = it.node_b;
                ok_a = climb_to_root(a, da, ra);
                ok_b = climb_to_root(b, db, rb);
                res  = '0;
                if (!ok_a || !ok_b) begin
                    res.walk_error = 1'b1;
                end else if (ra == rb) begin
                    while (da > db) begin
                        a  = parent_of(a);
                        da = da - 1;
                    end
                    while (db > da) begin
                        b  = parent_of(b);
                        db = db - 1;
                    end
                    while (a != b) begin
                        a = parent_of(a);
                        b = parent_of(b);
                    end
                    res.ancestor = a;
                    res.found    = 1'b1;
                end
                ancestor_q.push_back(res);
                return 1'b1;
            end
            default: return 1'b0;   // spare op: nothing happens
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Driver: offers queued items; valid holds until the item is taken
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin : drive
        bit q_now;
        bit drained;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            q_now = 1'b0;
            if (s_valid) begin
                q_now      = apply_to_forest(s_item);
                n_accepted <= n_accepted + 1;
                n_queries  <= n_queries + q_now;
                n_edges    <= n_edges + (s_item.op == OP_EDGE);
                n_clears   <= n_clears + (s_item.op == OP_CLEAR);
            end
            // all results of items taken so far, this one included, are back
            drained = (n_queries + q_now == n_results);
            if (stim_q.size() > 0 && (!stim_q[0].wait_results || drained) &&
                (steady || $urandom_range(99) >= 28)) begin
                s_item  <= stim_q[0].item;
                s_valid <= 1'b1;
                void'(stim_q.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: takes results with random back-pressure and checks them
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin : watch
        m_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                // only queries taken before this edge can have an answer
                if (n_results >= n_queries) begin
                    n_unexp <= n_unexp + 1;
                    $display("unexpected result: anc=%0d found=%b err=%b",
                             m_item.ancestor, m_item.found, m_item.walk_error);
                end else begin
                    want = ancestor_q.pop_front();
                    n_results <= n_results + 1;
                    n_found   <= n_found + want.found;
                    n_loops   <= n_loops + want.walk_error;
                    if (m_item.ancestor !== want.ancestor ||
                        m_item.found !== want.found ||
                        m_item.walk_error !== want.walk_error) begin
                        if (n_bad < 10)
                            $display(
                                "mismatch %0d: expected %0d/%b/%b, got %0d/%b/%b (anc/found/err)",
                                n_results, want.ancestor, want.found,
                                want.walk_error, m_item.ancestor,
                                m_item.found, m_item.walk_error);
                        n_bad <= n_bad + 1;
                    end
                end
            end
            m_ready <= !hold_off && (steady || $urandom_range(99) >= 28);
        end
    end

    // Long hold-off so the output register fills and the input stalls.
    initial begin
        wait (n_accepted >= 60);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYC) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------

    // Edge: x is the parent, y the child. Query: x and y are the two nodes.
    // Fields the op does not use get random values.
    function automatic void queue_op(logic [1:0] op, logic [ID_W-1:0] x,
                                     logic [ID_W-1:0] y);
        stim_t s;
        s.item.op          = op;
        s.item.parent_node = ID_W'($urandom_range(NODES_TB - 1));
        s.item.child_node  = ID_W'($urandom_range(NODES_TB - 1));
        s.item.node_a      = ID_W'($urandom_range(NODES_TB - 1));
        s.item.node_b      = ID_W'($urandom_range(NODES_TB - 1));
        if (op == OP_EDGE) begin
            s.item.parent_node = x;
            s.item.child_node  = y;
        end
        if (op == OP_QUERY) begin
            s.item.node_a = x;
            s.item.node_b = y;
        end
        s.wait_results = drain_next;
        drain_next     = 1'b0;
        stim_q.push_back(s);
    endfunction

    initial begin : main
        logic [ID_W-1:0] pool [10];
        int              n_rand;
        int              k;
        int              nq;
        bit              first;

        foreach (forest[i])
            forest[i] = '0;

        // directed: empty table, lowest and highest ids
        queue_op(OP_QUERY, '0, '0);          // same node twice
        queue_op(OP_QUERY, '1, '1);
        queue_op(OP_QUERY, '0, '1);          // two different roots
        // small tree: 1023 over 5 and 6, 5 over 7, 7 over 0
        queue_op(OP_EDGE, '1, 10'd5);
        queue_op(OP_EDGE, '1, 10'd6);
        queue_op(OP_EDGE, 10'd5, 10'd7);
        queue_op(OP_EDGE, 10'd7, '0);
        queue_op(OP_QUERY, '0, 10'd6);       // meet at the root
        queue_op(OP_QUERY, 10'd7, '0);       // second node deeper
        queue_op(OP_QUERY, '0, 10'd5);       // first node deeper
        queue_op(OP_QUERY, '1, '0);
        queue_op(OP_UNUSED, '0, '0);         // spare op, all ones
        stim_q[$].item = '1;
        queue_op(OP_QUERY, 10'd6, 10'd7);    // table unchanged by it
        // two-node loop
        queue_op(OP_EDGE, 10'd9, 10'd8);
        queue_op(OP_EDGE, 10'd8, 10'd9);
        queue_op(OP_QUERY, 10'd8, 10'd1);
        queue_op(OP_QUERY, 10'd1, 10'd9);
        // self loop on the root, then overwrite that edge
        queue_op(OP_EDGE, '1, '1);
        queue_op(OP_QUERY, '1, 10'd5);
        queue_op(OP_EDGE, 10'd2, '1);
        queue_op(OP_QUERY, 10'd6, 10'd2);
        queue_op(OP_CLEAR, '0, '0);
        queue_op(OP_QUERY, '0, 10'd6);       // roots again after clear

        // sender waits for every result before the random part
        drain_next = 1'b1;

        // random: mostly small well-formed trees with queries, some noise
        n_rand = 0;
        first  = 1'b1;
        while (n_rand < 165) begin
            if (first || $urandom_range(3) != 0) begin
                queue_op(OP_CLEAR, '0, '0);
                n_rand = n_rand + 1;
            end
            first = 1'b0;
            k = $urandom_range(10, 3);
            for (int i = 0; i < k; i++) begin
                pool[i] = ID_W'($urandom_range(NODES_TB - 1));
                if (i > 0) begin
                    queue_op(OP_EDGE, pool[$urandom_range(i - 1)], pool[i]);
                    n_rand = n_rand + 1;
                end
            end
            nq = $urandom_range(8, 3);
            for (int j = 0; j < nq; j++) begin
                if ($urandom_range(9) == 0) begin
                    case ($urandom_range(2))
                        0: queue_op(OP_UNUSED, '0, '0);
                        1: begin   // stray edge, may close a loop
                            queue_op(OP_EDGE, pool[$urandom_range(k - 1)],
                                     pool[$urandom_range(k - 1)]);
                            n_rand = n_rand + 1;
                        end
                        default: begin
                            queue_op(OP_QUERY,
                                     ID_W'($urandom_range(NODES_TB - 1)),
                                     pool[$urandom_range(k - 1)]);
                            n_rand = n_rand + 1;
                        end
                    endcase
                end else begin
                    queue_op(OP_QUERY, pool[$urandom_range(k - 1)],
                             pool[$urandom_range(k - 1)]);
                    n_rand = n_rand + 1;
                end
            end
        end
        n_total = stim_q.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        wait (n_accepted == n_total);
        wait (n_results == n_queries);
        // then wait on to catch any stray result
        repeat (2 * NODES_TB + 64) @(posedge aclk);

        $display("summary: %0d items taken (%0d clears, %0d edges, %0d queries)",
                 n_accepted, n_clears, n_edges, n_queries);
        $display("summary: %0d answers checked, %0d with a common root, %0d loops",
                 n_results, n_found, n_loops);
        if (n_bad == 0 && n_unexp == 0 && n_results == n_queries) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
